// File: src/fwwd_pkg.sv
// ----------------------------------------------------------------------------
// Failed wake window detector package
// Shared widths, reset values, register indexes, FSM states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package fwwd_pkg;

  localparam int DEPTH_DEF  = 4;
  localparam int TIME_W     = 64;
  localparam int WINDOW_W   = 40;
  localparam int LIMIT_W    = 3;
  localparam int COUNT_W    = 3;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 64;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 40'd10000000;
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 3'd3;

  localparam logic REQ_NOTE  = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW = 8'd0,
    REG_LIMIT  = 8'd1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load_note;   // latch time, restart scan
    logic load_clear;  // latch a clear request
    logic step;        // age test on one stored entry
    logic finish;      // append / clear, load result register
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } status_t;

endpackage

// File: src/fwwd_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Carries a note or clear request with the current time.
// ----------------------------------------------------------------------------
interface fwwd_req_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [fwwd_pkg::TIME_W-1:0] now_us;

  modport source (output valid, output req_type, output now_us, input ready);
  modport sink (input valid, input req_type, input now_us, output ready);
endinterface

// File: src/fwwd_res_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Carries the loop flag and retained failure count.
// ----------------------------------------------------------------------------
interface fwwd_res_if;
  logic                         valid;
  logic                         ready;
  logic                         loop_detected;
  logic [fwwd_pkg::COUNT_W-1:0] fail_count;

  modport source (output valid, output loop_detected, output fail_count, input ready);
  modport sink (input valid, input loop_detected, input fail_count, output ready);
endinterface

// File: src/fwwd_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Register index plus write data.
// ----------------------------------------------------------------------------
interface fwwd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [fwwd_pkg::CFG_IDX_W-1:0]  index;
  logic [fwwd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: src/fwwd_ctrl.sv
// ----------------------------------------------------------------------------
// Detector controller
// Accepts requests, sequences the entry scan and the final update.
// ----------------------------------------------------------------------------
module fwwd_ctrl (
  input  logic               clk,
  input  logic               rst,
  fwwd_req_if.sink           req,
  input  fwwd_pkg::status_t  status,
  output fwwd_pkg::cmd_t     cmd
);

  fwwd_pkg::state_t state;
  fwwd_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fwwd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req.ready  = 1'b0;
    case (state)
      fwwd_pkg::ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          if (req.req_type == fwwd_pkg::REQ_CLEAR) begin
            cmd.load_clear = 1'b1;
            state_next     = fwwd_pkg::ST_FINISH;
          end else begin
            cmd.load_note = 1'b1;
            state_next    = fwwd_pkg::ST_SCAN;
          end
        end
      end
      fwwd_pkg::ST_SCAN: begin
        if (status.scan_done) begin
          state_next = fwwd_pkg::ST_FINISH;
        end else begin
          cmd.step = 1'b1;
        end
      end
      fwwd_pkg::ST_FINISH: begin
        // hold until the result register can take the new result
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = fwwd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = fwwd_pkg::ST_IDLE;
      end
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state != fwwd_pkg::ST_IDLE))
    else $error("controller stayed idle after a request transfer");

  assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (state == fwwd_pkg::ST_IDLE))
    else $error("controller did not return to idle after finish");

  assert property (@(posedge clk) disable iff (rst)
    $countones({cmd.load_note, cmd.load_clear, cmd.step, cmd.finish}) <= 1)
    else $error("more than one datapath command in one cycle");

endmodule

// File: src/fwwd_dpath.sv
// ----------------------------------------------------------------------------
// Detector datapath
// Timestamp list with in-place compaction, config registers, result register.
// ----------------------------------------------------------------------------
module fwwd_dpath #(
  parameter int DEPTH = fwwd_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  fwwd_pkg::cmd_t              cmd,
  output fwwd_pkg::status_t           status,
  input  logic [fwwd_pkg::TIME_W-1:0] now_us,
  fwwd_cfg_if.sink                    cfg,
  fwwd_res_if.source                  res
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CMP_W = (CNT_W > fwwd_pkg::LIMIT_W) ? CNT_W : fwwd_pkg::LIMIT_W;

  logic [fwwd_pkg::WINDOW_W-1:0] window_us;
  logic [fwwd_pkg::LIMIT_W-1:0]  loop_limit;

  logic [fwwd_pkg::TIME_W-1:0]   stamp [DEPTH];
  logic [CNT_W-1:0]              count;
  logic [CNT_W-1:0]              scan_idx;
  logic [CNT_W-1:0]              kept;
  logic [fwwd_pkg::TIME_W-1:0]   now_hold;
  logic                          is_clear;

  logic                          out_valid;
  logic                          out_loop;
  logic [fwwd_pkg::COUNT_W-1:0]  out_count;

  logic [fwwd_pkg::TIME_W-1:0]   entry;
  logic [fwwd_pkg::TIME_W-1:0]   age;
  logic                          in_window;
  logic                          has_room;
  logic [CNT_W-1:0]              final_count;

  assign entry       = stamp[scan_idx[IDX_W-1:0]];
  assign age         = now_hold - entry;  // wrap-around difference
  assign in_window   = age < fwwd_pkg::TIME_W'(window_us);
  assign has_room    = kept < CNT_W'(DEPTH);
  assign final_count = has_room ? kept + CNT_W'(1) : kept;

  assign status.scan_done = (scan_idx == count);
  assign status.out_free  = !out_valid || res.ready;

  assign cfg.ready         = 1'b1;
  assign res.valid         = out_valid;
  assign res.loop_detected = out_loop;
  assign res.fail_count    = out_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_us  <= fwwd_pkg::WINDOW_RESET;
      loop_limit <= fwwd_pkg::LIMIT_RESET;
    end else if (cfg.valid) begin
      case (fwwd_pkg::reg_idx_t'(cfg.index))
        fwwd_pkg::REG_WINDOW: window_us  <= cfg.data[fwwd_pkg::WINDOW_W-1:0];
        fwwd_pkg::REG_LIMIT:  loop_limit <= cfg.data[fwwd_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // single write port: survivor move during scan, new stamp at finish
  always_ff @(posedge clk) begin
    if (cmd.step && in_window) begin
      stamp[kept[IDX_W-1:0]] <= entry;
    end else if (cmd.finish && !is_clear && has_room) begin
      stamp[kept[IDX_W-1:0]] <= now_hold;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_note || cmd.load_clear) begin
      now_hold <= now_us;
      is_clear <= cmd.load_clear;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      scan_idx <= '0;
      kept     <= '0;
    end else begin
      if (cmd.load_note || cmd.load_clear) begin
        scan_idx <= '0;
        kept     <= '0;
      end else if (cmd.step) begin
        scan_idx <= scan_idx + CNT_W'(1);
        if (in_window) begin
          kept <= kept + CNT_W'(1);
        end
      end
      if (cmd.finish) begin
        count <= is_clear ? '0 : final_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (is_clear) begin
        out_loop  <= 1'b0;
        out_count <= '0;
      end else begin
        out_loop  <= CMP_W'(final_count) > CMP_W'(loop_limit);
        out_count <= fwwd_pkg::COUNT_W'(final_count);
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    kept <= scan_idx)
    else $error("survivor count ran ahead of scan index");

  assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("stored count exceeds list depth");

  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.finish))
    else $error("result raised without a finish command");

  assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (scan_idx < count))
    else $error("scan step beyond stored entries");

endmodule

// File: src/failed_wake_window_detector.sv
// A note request goes from the transfer to a scan of the N stamps held before
// it; the age test runs one stored entry per cycle through a single 64-bit
// subtract and compare. The finish state then waits for a free result register
// and loads the result; a clear goes straight to it. Only one request is in
// flight, but a new one is taken while a result still waits on its channel.
// Reset: list emptied, window and limit to defaults; stamp contents not cleared.
// ----------------------------------------------------------------------------
// Failed wake window detector
// Sliding-window failure counter flagging wake loops.
// ----------------------------------------------------------------------------
module failed_wake_window_detector #(
  parameter int DEPTH = fwwd_pkg::DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  fwwd_req_if.sink   req,
  fwwd_res_if.source res,
  fwwd_cfg_if.sink   cfg
);

  fwwd_pkg::cmd_t    cmd;
  fwwd_pkg::status_t status;

  fwwd_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .status (status),
    .cmd    (cmd)
  );

  fwwd_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .status (status),
    .now_us (req.now_us),
    .cfg    (cfg),
    .res    (res)
  );

endmodule
